// ===== sv/source_comment_stripper_defines.svh =====
// Assertion macros shared by the comment stripper RTL.
`ifndef SOURCE_COMMENT_STRIPPER_DEFINES_SVH
`define SOURCE_COMMENT_STRIPPER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define SCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scs assertion failed");

// Next-cycle implication, checked out of reset
`define SCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scs assertion failed");

`else

`define SCS_ASSERT_IMP(label, ante, cons)
`define SCS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== sv/scs_pkg.sv =====
// Shared types and character constants for the comment stripper.
`default_nettype none

package scs_pkg;

  localparam int CHAR_BITS = 16;

  localparam logic [CHAR_BITS-1:0] CH_CR     = CHAR_BITS'(16'h000D);
  localparam logic [CHAR_BITS-1:0] CH_LF     = CHAR_BITS'(16'h000A);
  localparam logic [CHAR_BITS-1:0] CH_SLASH  = CHAR_BITS'(16'h002F);
  localparam logic [CHAR_BITS-1:0] CH_STAR   = CHAR_BITS'(16'h002A);
  localparam logic [CHAR_BITS-1:0] CH_BSLASH = CHAR_BITS'(16'h005C);
  localparam logic [CHAR_BITS-1:0] CH_SQUOTE = CHAR_BITS'(16'h0027);
  localparam logic [CHAR_BITS-1:0] CH_DQUOTE = CHAR_BITS'(16'h0022);
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = CHAR_BITS'(16'h0020);

  // Scanner mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_QUOTE  = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } mode_t;

  // One classified input: up to two output characters or a bare end marker
  typedef struct packed {
    logic [CHAR_BITS-1:0] ch0;
    logic [CHAR_BITS-1:0] ch1;
    logic                 two;
    logic                 char_valid;
    logic                 eot;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

`default_nettype wire

// ===== sv/source_comment_stripper.sv =====
// Comment stripper for C-style source text: one character per request in, stripped text out.
//
// s_axis carries one character per request; s_axis_tlast marks the last character of
// a text. m_axis returns the stripped characters; m_axis_tuser[0] is high when
// m_axis_tdata holds a character (low on a bare end marker), m_axis_tuser[1] marks the
// last result of one input request, and m_axis_tlast marks the final result of a text.
// The scanner classifies each character as it is accepted; its results pass through the
// entry queue and then the output register to m_axis. Input is taken every cycle while the
// entry queue has room, so a steady stream runs at one character per cycle. An input
// that yields two results (a held slash and the character after it) is sent as two
// successive results, one per load of the single output register.
// When the sink stalls, the output register holds and the queue of QUEUE_DEPTH
// entries absorbs input until full, then s_axis_tready drops. Reset empties the queue
// and the output register and returns the scanner to normal text.
`default_nettype none
`include "source_comment_stripper_defines.svh"

module source_comment_stripper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] char_code
  input  wire logic        s_axis_tlast,  // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] out_char
  output logic [1:0]       m_axis_tuser,  // [0] char_valid, [1] last_of_run
  output logic             m_axis_tlast   // text_done
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic            take;
  logic            q_push;
  scs_pkg::entry_t q_in;
  logic            q_pop;
  logic            q_valid;
  scs_pkg::entry_t q_head;
  logic            q_full;
  logic [CW-1:0]   q_count;
  logic            front_idle;

  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  scs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .char_code   (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .push        (q_push),
    .entry       (q_in),
    .at_reset    (front_idle)
  );

  scs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head),
    .full       (q_full),
    .count      (q_count)
  );

  scs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tuser    (m_axis_tuser),
    .m_tlast    (m_axis_tlast)
  );

  // Checks
  `SCS_ASSERT_IMP(a_no_push_full, q_push, !q_full || q_pop)
  `SCS_ASSERT_IMP(a_count_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH))
  `SCS_ASSERT_IMP(a_done_ends_run, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1])
  `SCS_ASSERT_IMP(a_bare_marker, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && m_axis_tdata == 16'h0000)
  `SCS_ASSERT_NXT(a_text_end_reset, take && s_axis_tlast, front_idle)

endmodule

`default_nettype wire

// ===== sv/scs_front.sv =====
// Front end: scans one character per request and builds queue entries.
`default_nettype none

module scs_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire logic [scs_pkg::CHAR_BITS-1:0] char_code,
  input  wire logic                          end_of_text,
  output logic                               push,
  output scs_pkg::entry_t                    entry,
  output logic                               at_reset
);

  scs_pkg::mode_t mode, mode_next;
  logic quote_is_double, quote_is_double_next;
  logic escape_pending, escape_pending_next;
  logic slash_held, slash_held_next;
  logic star_held, star_held_next;
  logic newline_seen_in_block, newline_seen_in_block_next;

  logic is_slash, is_star, is_nl, is_quote, is_dq;
  logic [scs_pkg::CHAR_BITS-1:0] close_ch;
  logic [scs_pkg::CHAR_BITS-1:0] e0, e1;
  logic [1:0] n_emit;

  assign is_slash = (char_code == scs_pkg::CH_SLASH);
  assign is_star  = (char_code == scs_pkg::CH_STAR);
  assign is_nl    = (char_code == scs_pkg::CH_CR) || (char_code == scs_pkg::CH_LF);
  assign is_dq    = (char_code == scs_pkg::CH_DQUOTE);
  assign is_quote = is_dq || (char_code == scs_pkg::CH_SQUOTE);
  assign close_ch = quote_is_double ? scs_pkg::CH_DQUOTE : scs_pkg::CH_SQUOTE;

  // Next scanner state
  always_comb begin
    mode_next                  = mode;
    quote_is_double_next       = quote_is_double;
    escape_pending_next        = escape_pending;
    slash_held_next            = slash_held;
    star_held_next             = star_held;
    newline_seen_in_block_next = newline_seen_in_block;
    unique case (mode)
      scs_pkg::MODE_NORMAL: begin
        if (slash_held) begin
          slash_held_next = 1'b0;
          if (is_slash) begin
            mode_next = scs_pkg::MODE_LINE;
          end else if (is_star) begin
            mode_next                  = scs_pkg::MODE_BLOCK;
            star_held_next             = 1'b0;
            newline_seen_in_block_next = 1'b0;
          end else if (is_quote) begin
            mode_next            = scs_pkg::MODE_QUOTE;
            quote_is_double_next = is_dq;
            escape_pending_next  = 1'b0;
          end
        end else if (is_slash && !end_of_text) begin
          slash_held_next = 1'b1;
        end else if (is_quote) begin
          mode_next            = scs_pkg::MODE_QUOTE;
          quote_is_double_next = is_dq;
          escape_pending_next  = 1'b0;
        end
      end
      scs_pkg::MODE_QUOTE: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (char_code == scs_pkg::CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (char_code == close_ch) begin
          mode_next = scs_pkg::MODE_NORMAL;
        end
      end
      scs_pkg::MODE_LINE: begin
        if (is_nl) begin
          mode_next = scs_pkg::MODE_NORMAL;
        end
      end
      scs_pkg::MODE_BLOCK: begin
        if (star_held && is_slash) begin
          star_held_next             = 1'b0;
          mode_next                  = scs_pkg::MODE_NORMAL;
          newline_seen_in_block_next = 1'b0;
        end else begin
          star_held_next = 1'b0;
          if (is_star) begin
            star_held_next = !end_of_text;
          end else if (is_nl) begin
            newline_seen_in_block_next = 1'b1;
          end
        end
      end
      default: mode_next = scs_pkg::MODE_NORMAL;
    endcase
    // end of text puts everything back to reset
    if (end_of_text) begin
      mode_next                  = scs_pkg::MODE_NORMAL;
      quote_is_double_next       = 1'b0;
      escape_pending_next        = 1'b0;
      slash_held_next            = 1'b0;
      star_held_next             = 1'b0;
      newline_seen_in_block_next = 1'b0;
    end
  end

  // Characters emitted for this request
  always_comb begin
    e0     = '0;
    e1     = '0;
    n_emit = 2'd0;
    unique case (mode)
      scs_pkg::MODE_NORMAL: begin
        if (slash_held) begin
          if (!is_slash && !is_star) begin
            e0     = scs_pkg::CH_SLASH;
            e1     = char_code;
            n_emit = 2'd2;
          end
        end else if (!(is_slash && !end_of_text)) begin
          e0     = char_code;
          n_emit = 2'd1;
        end
      end
      scs_pkg::MODE_QUOTE: begin
        e0     = char_code;
        n_emit = 2'd1;
      end
      scs_pkg::MODE_LINE: begin
        if (is_nl) begin
          e0     = char_code;
          n_emit = 2'd1;
        end
      end
      scs_pkg::MODE_BLOCK: begin
        if (star_held && is_slash) begin
          if (!newline_seen_in_block) begin
            e0     = scs_pkg::CH_SPACE;
            n_emit = 2'd1;
          end
        end else if (is_nl) begin
          e0     = char_code;
          n_emit = 2'd1;
        end
      end
      default: n_emit = 2'd0;
    endcase
  end

  // Queue entry; a silent final character still yields an end marker
  assign push             = take && ((n_emit != 2'd0) || end_of_text);
  assign entry.ch0        = e0;
  assign entry.ch1        = e1;
  assign entry.two        = (n_emit == 2'd2);
  assign entry.char_valid = (n_emit != 2'd0);
  assign entry.eot        = end_of_text;

  assign at_reset = (mode == scs_pkg::MODE_NORMAL) && !quote_is_double && !escape_pending &&
                    !slash_held && !star_held && !newline_seen_in_block;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                  <= scs_pkg::MODE_NORMAL;
      quote_is_double       <= 1'b0;
      escape_pending        <= 1'b0;
      slash_held            <= 1'b0;
      star_held             <= 1'b0;
      newline_seen_in_block <= 1'b0;
    end else if (take) begin
      mode                  <= mode_next;
      quote_is_double       <= quote_is_double_next;
      escape_pending        <= escape_pending_next;
      slash_held            <= slash_held_next;
      star_held             <= star_held_next;
      newline_seen_in_block <= newline_seen_in_block_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/scs_queue.sv =====
// Small entry queue between the scanner and the output stage.
`default_nettype none

module scs_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire scs_pkg::entry_t            push_entry,
  input  wire logic                       pop,
  output logic                            head_valid,
  output scs_pkg::entry_t                 head,
  output logic                            full,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  scs_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/scs_back.sv =====
// Back end: splits queue entries into output requests, registered toward the sink.
`default_nettype none

module scs_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire scs_pkg::entry_t               head,
  output logic                               pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [scs_pkg::CHAR_BITS-1:0]      m_tdata,
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast
);

  logic half;
  logic load;
  logic first_of_two;

  assign load         = (!m_tvalid || m_tready) && head_valid;
  assign first_of_two = head.two && !half;
  assign pop          = load && !first_of_two;

  // Output valid and second-half tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      half     <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        half <= first_of_two;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (first_of_two) begin
        m_tdata <= head.ch0;
        m_tuser <= {1'b0, 1'b1};
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= head.two ? head.ch1 : head.ch0;
        m_tuser <= {1'b1, head.char_valid};
        m_tlast <= head.eot;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/source_comment_stripper_tb.sv =====
// Self-checking testbench for source_comment_stripper: directed and random texts.
`default_nettype none

module source_comment_stripper_tb;

  // One character request with its end-of-text flag
  typedef struct {
    logic [15:0] ch;
    logic        eot;
  } text_char_t;

  // One stripped-text result as the block should return it
  typedef struct {
    logic [15:0] ch;
    logic        char_valid;
    logic        run_end;
    logic        text_end;
  } strip_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [15:0] char_code
  logic        s_axis_tlast = 1'b0;  // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // [15:0] out_char
  logic [1:0]  m_axis_tuser;  // [0] char_valid, [1] last_of_run
  logic        m_axis_tlast;  // text_done

  source_comment_stripper uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_char_t    pending_chars[$];
  strip_result_t stripped_out[$];
  text_char_t    next_char;
  strip_result_t got_result;
  logic          in_taken = 1'b0;
  int            n_accepted = 0;
  int            error_count = 0;
  int            hold_cnt = 0;
  logic          hold_done = 1'b0;

  // No idling on either side while this window of requests goes through
  wire quiet_phase = (n_accepted >= 600) && (n_accepted < 900);

  // Scanner state tracked alongside the block
  scs_pkg::mode_t scan_mode = scs_pkg::MODE_NORMAL;
  logic        in_dquote = 1'b0;
  logic        escape_on = 1'b0;
  logic        slash_held = 1'b0;
  logic        star_held = 1'b0;
  logic        nl_seen = 1'b0;
  logic [15:0] emit_buf[2];
  int          emit_cnt;

  task automatic emit_char(input logic [15:0] c);
    if (emit_cnt < 2) begin
      emit_buf[emit_cnt] = c;
      emit_cnt++;
    end
  endtask

  // Plain text: a slash waits for the next char, quotes open a literal
  task automatic scan_normal(input logic [15:0] c, input logic eot);
    if (c == scs_pkg::CH_SLASH && !eot) begin
      slash_held = 1'b1;
    end else if (c == scs_pkg::CH_DQUOTE || c == scs_pkg::CH_SQUOTE) begin
      emit_char(c);
      scan_mode = scs_pkg::MODE_QUOTE;
      in_dquote = (c == scs_pkg::CH_DQUOTE);
      escape_on = 1'b0;
    end else begin
      emit_char(c);
    end
  endtask

  // Advance the scanner by one character and queue the results it should produce
  task automatic predict_strip(input logic [15:0] c, input logic eot);
    logic          closed;
    strip_result_t r;
    closed = 1'b0;
    emit_cnt = 0;
    case (scan_mode)
      scs_pkg::MODE_NORMAL: begin
        if (slash_held) begin
          slash_held = 1'b0;
          if (c == scs_pkg::CH_SLASH) begin
            scan_mode = scs_pkg::MODE_LINE;
          end else if (c == scs_pkg::CH_STAR) begin
            scan_mode = scs_pkg::MODE_BLOCK;
            star_held = 1'b0;
            nl_seen = 1'b0;
          end else begin
            emit_char(scs_pkg::CH_SLASH);
            scan_normal(c, eot);
          end
        end else begin
          scan_normal(c, eot);
        end
      end
      scs_pkg::MODE_QUOTE: begin
        emit_char(c);
        if (escape_on) begin
          escape_on = 1'b0;
        end else if (c == scs_pkg::CH_BSLASH) begin
          escape_on = 1'b1;
        end else if (c == (in_dquote ? scs_pkg::CH_DQUOTE : scs_pkg::CH_SQUOTE)) begin
          scan_mode = scs_pkg::MODE_NORMAL;
        end
      end
      scs_pkg::MODE_LINE: begin
        if (c == scs_pkg::CH_CR || c == scs_pkg::CH_LF) begin
          emit_char(c);
          scan_mode = scs_pkg::MODE_NORMAL;
        end
      end
      default: begin
        // star-slash closes; a comment without line ends becomes one space
        if (star_held) begin
          star_held = 1'b0;
          if (c == scs_pkg::CH_SLASH) begin
            if (!nl_seen) emit_char(scs_pkg::CH_SPACE);
            scan_mode = scs_pkg::MODE_NORMAL;
            nl_seen = 1'b0;
            closed = 1'b1;
          end
        end
        if (!closed) begin
          if (c == scs_pkg::CH_STAR) begin
            if (!eot) star_held = 1'b1;
          end else if (c == scs_pkg::CH_CR || c == scs_pkg::CH_LF) begin
            emit_char(c);
            nl_seen = 1'b1;
          end
        end
      end
    endcase
    for (int k = 0; k < emit_cnt; k++) begin
      r.ch = emit_buf[k];
      r.char_valid = 1'b1;
      r.run_end = (k == emit_cnt - 1);
      r.text_end = eot && (k == emit_cnt - 1);
      stripped_out.push_back(r);
    end
    if (eot) begin
      if (emit_cnt == 0) begin
        r.ch = '0;
        r.char_valid = 1'b0;
        r.run_end = 1'b1;
        r.text_end = 1'b1;
        stripped_out.push_back(r);
      end
      scan_mode = scs_pkg::MODE_NORMAL;
      in_dquote = 1'b0;
      escape_on = 1'b0;
      slash_held = 1'b0;
      star_held = 1'b0;
      nl_seen = 1'b0;
    end
  endtask

  // Stimulus helpers
  task automatic push_char(input logic [15:0] c);
    text_char_t t;
    t.ch = c;
    t.eot = 1'b0;
    pending_chars.push_back(t);
  endtask

  task automatic close_text();
    text_char_t t;
    t = pending_chars.pop_back();
    t.eot = 1'b1;
    pending_chars.push_back(t);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(16'(s[i]));
    close_text();
  endtask

  function automatic logic [15:0] pick_special();
    case ($urandom_range(0, 7))
      0: return scs_pkg::CH_SLASH;
      1: return scs_pkg::CH_STAR;
      2: return scs_pkg::CH_BSLASH;
      3: return scs_pkg::CH_SQUOTE;
      4: return scs_pkg::CH_DQUOTE;
      5: return scs_pkg::CH_CR;
      6: return scs_pkg::CH_LF;
      default: return scs_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [15:0] pick_letter();
    return 16'($urandom_range(16'h61, 16'h7A));
  endfunction

  // One lexical piece: mostly well-formed, some noise
  task automatic add_token();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      n = $urandom_range(1, 5);
      repeat (n) push_char(($urandom_range(0, 4) == 0) ? scs_pkg::CH_SPACE : pick_letter());
    end else if (kind < 32) begin
      push_char(scs_pkg::CH_DQUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: begin push_char(scs_pkg::CH_BSLASH); push_char(pick_special()); end
          1: push_char(pick_special());
          default: push_char(pick_letter());
        endcase
      end
      push_char(scs_pkg::CH_DQUOTE);
    end else if (kind < 40) begin
      push_char(scs_pkg::CH_SQUOTE);
      if ($urandom_range(0, 1)) push_char(scs_pkg::CH_BSLASH);
      push_char($urandom_range(0, 1) ? pick_special() : pick_letter());
      push_char(scs_pkg::CH_SQUOTE);
    end else if (kind < 52) begin
      push_char(scs_pkg::CH_SLASH);
      push_char(scs_pkg::CH_SLASH);
      n = $urandom_range(0, 6);
      repeat (n) push_char($urandom_range(0, 2) == 0 ? pick_special() : pick_letter());
      case ($urandom_range(0, 2))
        0: push_char(scs_pkg::CH_CR);
        1: push_char(scs_pkg::CH_LF);
        default: begin push_char(scs_pkg::CH_CR); push_char(scs_pkg::CH_LF); end
      endcase
    end else if (kind < 68) begin
      push_char(scs_pkg::CH_SLASH);
      push_char(scs_pkg::CH_STAR);
      n = $urandom_range(0, 6);
      repeat (n) push_char($urandom_range(0, 1) ? pick_special() : pick_letter());
      if ($urandom_range(0, 3) == 0) push_char(scs_pkg::CH_STAR);
      push_char(scs_pkg::CH_STAR);
      push_char(scs_pkg::CH_SLASH);
    end else if (kind < 76) begin
      push_char($urandom_range(0, 1) ? scs_pkg::CH_CR : scs_pkg::CH_LF);
    end else if (kind < 85) begin
      push_char(scs_pkg::CH_SLASH);
      push_char(pick_letter());
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: push_char(16'($urandom_range(0, 16'hFFFF)));
          1: push_char($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
          default: push_char(pick_special());
        endcase
      end
    end
  endtask

  // Sender: next request at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_chars.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 10)) begin
        next_char = pending_chars.pop_front();
        s_axis_tdata <= next_char.ch;
        s_axis_tlast <= next_char.eot;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to fill the block
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_accepted >= 300) begin
      hold_cnt <= 80;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_phase || ($urandom_range(0, 99) >= 10);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_strip(s_axis_tdata, s_axis_tlast);
        n_accepted <= n_accepted + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (stripped_out.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: char %h valid %b run_end %b text_end %b",
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
        end else begin
          got_result = stripped_out.pop_front();
          if (m_axis_tdata !== got_result.ch || m_axis_tuser[0] !== got_result.char_valid ||
              m_axis_tuser[1] !== got_result.run_end || m_axis_tlast !== got_result.text_end) begin
            error_count++;
            if (error_count <= 10)
              $display({"result differs: exp char %h valid %b run_end %b text_end %b, ",
                        "got %h %b %b %b"},
                       got_result.ch, got_result.char_valid, got_result.run_end,
                       got_result.text_end, m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1],
                       m_axis_tlast);
          end
        end
      end
    end
  end

  initial begin
    int guard;
    // Directed: slash at end, held slash then other char, line and block comments,
    // escaped quote, unclosed literal, unclosed comment, extreme codes
    push_text("/");
    push_text("a/b");
    push_text("//\n");
    push_text("/*\015*/");
    push_text("/**/");
    push_text("'\\''");
    push_text("\"x");
    push_text("/*");
    push_char(16'h0000);
    push_char(16'hFFFF);
    close_text();

    // Random texts of tokens, a few of them short special-character noise
    while (pending_chars.size() < 1600) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) push_char(pick_special());
      end else begin
        repeat ($urandom_range(1, 12)) add_token();
      end
      close_text();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || s_axis_tvalid) @(posedge clk);
    guard = 0;
    while (stripped_out.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (stripped_out.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", stripped_out.size());
    end

    if (error_count == 0) begin
      $display("source_comment_stripper: match");
    end else begin
      $display("source_comment_stripper: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("source_comment_stripper: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
